@@ design/svpq_pkg.sv @@
// ----------------------------------------------------------------------------
// svpq_pkg: shared types and constants of the sorted value priority queue
// Holds the capacity, the derived widths, the command codes and the command
// record that travels from the front part through the queue to the back part.
// ----------------------------------------------------------------------------
package svpq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_TAKE   = 2'd1,
    OP_DROP   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] quantity;
    logic [15:0] cost;
    logic [31:0] key;
  } cmd_t;

endpackage

@@ design/svpq_front.sv @@
// ----------------------------------------------------------------------------
// svpq_front: command intake
// Accepts an item, decodes its mode and forms the 32-bit sort key as the
// product of quantity and cost, then offers the command to the queue.
// ----------------------------------------------------------------------------
module svpq_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [1:0]   mode_i,
  input  logic [15:0]  quantity_i,
  input  logic [15:0]  cost_i,
  output logic         busy_o,
  input  logic         q_full_i,
  output logic         push_o,
  output svpq_pkg::cmd_t cmd_o
);
  import svpq_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q;
  logic accept;

  assign busy_o = valid_q && q_full_i;
  assign accept = start_i && !busy_o;
  assign push_o = valid_q && !q_full_i;
  assign cmd_o  = cmd_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op       <= op_e'(mode_i);
      cmd_q.quantity <= quantity_i;
      cmd_q.cost     <= cost_i;
      cmd_q.key      <= 32'(quantity_i) * 32'(cost_i);
    end
  end

endmodule

@@ design/svpq_queue.sv @@
// ----------------------------------------------------------------------------
// svpq_queue: command queue
// A short first-in first-out buffer of commands between intake and execution.
// ----------------------------------------------------------------------------
module svpq_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  svpq_pkg::cmd_t wr_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output svpq_pkg::cmd_t rd_cmd_o
);
  import svpq_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   fill_q, fill_d;
  logic              do_push, do_pop;

  assign full_o   = fill_q == (QPTR_W + 1)'(QDEPTH);
  assign empty_o  = fill_q == '0;
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && !empty_o;
  assign rd_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

@@ design/svpq_back.sv @@
// ----------------------------------------------------------------------------
// svpq_back: sorted entry array and command execution
// Keeps the entries in ascending key order in a shifting register array and
// carries out one command per cycle, registering its result.
// ----------------------------------------------------------------------------
module svpq_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  output logic           pop_o,
  input  svpq_pkg::cmd_t cmd_i,
  output logic           valid_o,
  output logic [15:0]    out_quantity_o,
  output logic [15:0]    out_cost_o,
  output logic [1:0]     status_o,
  output logic [4:0]     entry_count_o,
  output logic           is_empty_o
);
  import svpq_pkg::*;

  logic [31:0]      key_q  [CAPACITY];
  logic [15:0]      qty_q  [CAPACITY];
  logic [15:0]      cost_q [CAPACITY];
  logic [31:0]      key_d  [CAPACITY];
  logic [15:0]      qty_d  [CAPACITY];
  logic [15:0]      cost_d [CAPACITY];
  logic [CAPACITY-1:0] lt;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] top_idx;
  logic             full, none, shift_en;
  logic             valid_q;
  logic [15:0]      oq_q, oq_d, oc_q, oc_d;
  status_e          st_q, st_d;

  assign pop_o   = !empty_i;
  assign full    = count_q == CNT_W'(CAPACITY);
  assign none    = count_q == '0;
  assign top_idx = IDX_W'(count_q - 1'b1);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CNT_W'(i) < count_q) && (key_q[i] < cmd_i.key);
    end
  end

  always_comb begin
    count_d  = count_q;
    oq_d     = '0;
    oc_d     = '0;
    st_d     = ST_DONE;
    shift_en = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      key_d[i]  = key_q[i];
      qty_d[i]  = qty_q[i];
      cost_d[i] = cost_q[i];
    end
    if (pop_o) begin
      unique case (cmd_i.op)
        OP_INSERT: begin
          if (full) begin
            st_d = ST_FULL;
          end else begin
            shift_en = 1'b1;
            count_d  = count_q + 1'b1;
            for (int i = 0; i < CAPACITY; i++) begin
              if (!lt[i]) begin
                if (i == 0 || lt[(i == 0) ? 0 : i - 1]) begin
                  key_d[i]  = cmd_i.key;
                  qty_d[i]  = cmd_i.quantity;
                  cost_d[i] = cmd_i.cost;
                end else begin
                  key_d[i]  = key_q[(i == 0) ? 0 : i - 1];
                  qty_d[i]  = qty_q[(i == 0) ? 0 : i - 1];
                  cost_d[i] = cost_q[(i == 0) ? 0 : i - 1];
                end
              end
            end
          end
        end
        OP_TAKE: begin
          if (none) begin
            st_d = ST_EMPTY;
          end else begin
            oq_d    = qty_q[top_idx];
            oc_d    = cost_q[top_idx];
            count_d = count_q - 1'b1;
          end
        end
        OP_DROP: begin
          if (none) begin
            st_d = ST_EMPTY;
          end else begin
            shift_en = 1'b1;
            count_d  = count_q - 1'b1;
            for (int i = 0; i < CAPACITY - 1; i++) begin
              key_d[i]  = key_q[i + 1];
              qty_d[i]  = qty_q[i + 1];
              cost_d[i] = cost_q[i + 1];
            end
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
          st_d = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < CAPACITY; i++) begin
        key_q[i]  <= key_d[i];
        qty_q[i]  <= qty_d[i];
        cost_q[i] <= cost_d[i];
      end
    end
    oq_q <= oq_d;
    oc_q <= oc_d;
    st_q <= st_d;
  end

  assign valid_o        = valid_q;
  assign out_quantity_o = oq_q;
  assign out_cost_o     = oc_q;
  assign status_o       = st_q;
  assign entry_count_o  = 5'(count_q);
  assign is_empty_o     = count_q == '0;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_o)
    else $error("A command produced no result.");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.op == OP_CLEAR) |=> (count_q == '0))
    else $error("Clear left entries in the store.");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.op == OP_INSERT && !full) |=> (count_q == $past(count_q) + 1'b1))
    else $error("Insert did not add an entry.");

  a_lowest_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (key_q[0] <= key_q[1]))
    else $error("Lowest entries are out of order.");

endmodule

@@ design/sorted_value_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// sorted_value_priority_queue_top: sorted priority queue of priced entries
// Stores up to CAPACITY (quantity, cost) entries ordered by quantity times
// cost and executes insert, take-largest, drop-smallest and clear commands.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low, and one item can be
// taken in every cycle. Each item yields exactly one result, shown with
// valid_o high for a single cycle. The item passes the intake register that
// forms the key product and the command queue, then the sorted array executes
// the command and registers the result. The sorted array finishes one command
// per cycle, so the queue never backs up and busy_o stays low in steady
// operation. Results must be captured in the cycle they are shown.
module sorted_value_priority_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] quantity_i,
  input  logic [15:0] cost_i,
  output logic        valid_o,
  output logic [15:0] out_quantity_o,
  output logic [15:0] out_cost_o,
  output logic [1:0]  status_o,
  output logic [4:0]  entry_count_o,
  output logic        is_empty_o
);
  import svpq_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, q_full, q_empty, pop;

  svpq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .mode_i     (mode_i),
    .quantity_i (quantity_i),
    .cost_i     (cost_i),
    .busy_o     (busy_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  svpq_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wr_cmd_i (push_cmd),
    .full_o   (q_full),
    .pop_i    (pop),
    .empty_o  (q_empty),
    .rd_cmd_o (pop_cmd)
  );

  svpq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .cmd_i          (pop_cmd),
    .valid_o        (valid_o),
    .out_quantity_o (out_quantity_o),
    .out_cost_o     (out_cost_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o)
  );

endmodule
